FILE: hdl/hkst_pkg.sv
// Package for the hashed key sum table: table geometry, field widths,
// command codes and the structs passed between the sequencer and the store.
// Depends on nothing; every other file uses it by scoped names.
package hkst_pkg;

  localparam int TABLE_SIZE = 128;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [31:0] TABLE_SIZE_W = 32'(TABLE_SIZE);

  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int SUM_W = 64;
  localparam int SLOT_W = 7;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  localparam logic [CMD_W-1:0] CMD_ACC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
  } wr_req_t;

endpackage

FILE: hdl/hkst_store.sv
// Slot store of the hashed key sum table: key and sum memories with one
// registered read port, one write port and a bank of valid bits.
// Depends on hkst_pkg for geometry and the entry and write structs.
module hkst_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [hkst_pkg::IDX_W-1:0] rd_addr,
  input  hkst_pkg::wr_req_t          wr,
  output hkst_pkg::entry_t           rd_entry
);

  logic [hkst_pkg::KEY_W-1:0] key_mem [hkst_pkg::TABLE_SIZE];
  logic [hkst_pkg::SUM_W-1:0] sum_mem [hkst_pkg::TABLE_SIZE];
  logic [hkst_pkg::TABLE_SIZE-1:0] valid;

  logic                       rd_valid;
  logic [hkst_pkg::KEY_W-1:0] rd_key;
  logic [hkst_pkg::SUM_W-1:0] rd_sum;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr] <= wr.key;
      sum_mem[wr.addr] <= wr.sum;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_addr];
    rd_key   <= key_mem[rd_addr];
    rd_sum   <= sum_mem[rd_addr];
  end

  // A slot that was never written since the last clear reads as empty.
  always_comb begin
    rd_entry.valid = rd_valid;
    rd_entry.key   = rd_valid ? rd_key : hkst_pkg::EMPTY_KEY;
    rd_entry.sum   = rd_valid ? rd_sum : '0;
  end

endmodule

FILE: hdl/hkst_probe_alu.sv
// Shared probe unit: compares a slot's key with the probed key and forms
// the slot's new running sum.
// Depends on hkst_pkg for the entry struct and field widths.
module hkst_probe_alu (
  input  hkst_pkg::entry_t           entry,
  input  logic [hkst_pkg::KEY_W-1:0] probe_key,
  input  logic [hkst_pkg::SUM_W-1:0] amount,
  output logic                       take,
  output logic [hkst_pkg::SUM_W-1:0] new_sum
);

  always_comb begin
    take    = !entry.valid || (entry.key == probe_key);
    new_sum = entry.sum + amount;
  end

endmodule

FILE: hdl/hashed_key_sum_table.sv
// Hashed key sum table: an open-addressing table that keeps one 64-bit
// running sum per 32-bit key, with linear probing from slot key mod 128.
// Depends on hkst_pkg, hkst_store and hkst_probe_alu.
//
// An item is taken at a rising edge with start high and busy low. Each item
// gives one result, shown for one cycle with done high; the receiver takes
// it at the edge that ends that cycle and cannot stall it.
// How each item runs from the accepting edge until its result is shown:
//   accumulate: probes from its home slot, busy until it finds its key or
//     claims an empty slot; the store returns one slot per cycle.
//   accumulate into a full table: 128 probes and a home reread.
//   accumulate with the reserved key, or read: one registered slot read while busy.
//   clear, or the unused command: the result is shown, never busy.
// A new item may be taken in the cycle its predecessor's result is shown.
// Clear resets all valid bits at once. Reset empties the table the
// same way and leaves the block idle with no result pending.
module hashed_key_sum_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [hkst_pkg::CMD_W-1:0]  command,
  input  logic [hkst_pkg::KEY_W-1:0]  key,
  input  logic [hkst_pkg::SUM_W-1:0]  amount,
  input  logic [hkst_pkg::SLOT_W-1:0] slot,
  output logic                        done,
  output logic                        status,
  output logic [hkst_pkg::SLOT_W-1:0] slot_used,
  output logic                        occupied,
  output logic [hkst_pkg::KEY_W-1:0]  entry_key,
  output logic [hkst_pkg::SUM_W-1:0]  entry_total
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  localparam logic [hkst_pkg::IDX_W-1:0] LAST_IDX = hkst_pkg::IDX_W'(hkst_pkg::TABLE_SIZE - 1);

  logic [1:0]                 state;
  logic [hkst_pkg::CMD_W-1:0] cmd_reg;
  logic [hkst_pkg::KEY_W-1:0] key_reg;
  logic [hkst_pkg::SUM_W-1:0] amount_reg;
  logic [hkst_pkg::IDX_W-1:0] idx;
  logic [hkst_pkg::IDX_W-1:0] home;
  logic [hkst_pkg::IDX_W-1:0] probes;
  logic                       status_reg;

  logic [hkst_pkg::IDX_W-1:0] home_in;
  logic [hkst_pkg::IDX_W-1:0] slot_in;
  logic [hkst_pkg::IDX_W-1:0] idx_next;
  logic [hkst_pkg::IDX_W-1:0] rd_addr;
  logic                       accept;
  logic                       last_probe;
  hkst_pkg::entry_t           rd_entry;
  hkst_pkg::wr_req_t          wr;
  logic                       take;
  logic [hkst_pkg::SUM_W-1:0] new_sum;

  hkst_store u_store (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept && (command == hkst_pkg::CMD_CLEAR)),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  hkst_probe_alu u_alu (
    .entry     (rd_entry),
    .probe_key (key_reg),
    .amount    (amount_reg),
    .take      (take),
    .new_sum   (new_sum)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    home_in    = hkst_pkg::IDX_W'(key % hkst_pkg::TABLE_SIZE_W);
    slot_in    = hkst_pkg::IDX_W'(32'(slot) % hkst_pkg::TABLE_SIZE_W);
    idx_next   = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    last_probe = (probes == LAST_IDX);
    if (state == ST_IDLE) begin
      rd_addr = (command == hkst_pkg::CMD_READ) ? slot_in : home_in;
    end else if (last_probe) begin
      rd_addr = home;
    end else begin
      rd_addr = idx_next;
    end
    wr.en   = (state == ST_PROBE) && take;
    wr.addr = idx;
    wr.key  = key_reg;
    wr.sum  = new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_reg    <= command;
            key_reg    <= key;
            amount_reg <= amount;
            home       <= home_in;
            probes     <= '0;
            case (command)
              hkst_pkg::CMD_ACC: begin
                idx <= home_in;
                if (key == hkst_pkg::EMPTY_KEY) begin
                  status_reg <= 1'b1;
                  state      <= ST_REPORT;
                end else begin
                  state <= ST_PROBE;
                end
              end
              hkst_pkg::CMD_READ: begin
                idx        <= slot_in;
                status_reg <= 1'b0;
                state      <= ST_REPORT;
              end
              default: begin
                done        <= 1'b1;
                status      <= 1'b0;
                slot_used   <= '0;
                occupied    <= 1'b0;
                entry_key   <= hkst_pkg::EMPTY_KEY;
                entry_total <= '0;
              end
            endcase
          end
        end
        ST_PROBE: begin
          if (take) begin
            done        <= 1'b1;
            status      <= 1'b0;
            slot_used   <= hkst_pkg::SLOT_W'(idx);
            occupied    <= 1'b1;
            entry_key   <= key_reg;
            entry_total <= new_sum;
            state       <= ST_IDLE;
          end else if (last_probe) begin
            idx        <= home;
            status_reg <= 1'b1;
            state      <= ST_REPORT;
          end else begin
            idx    <= idx_next;
            probes <= probes + 1'b1;
          end
        end
        ST_REPORT: begin
          done        <= 1'b1;
          status      <= status_reg;
          slot_used   <= hkst_pkg::SLOT_W'(idx);
          occupied    <= rd_entry.valid;
          entry_key   <= rd_entry.key;
          entry_total <= rd_entry.sum;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only follows an accepted item or work in progress.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without an item in progress");

  // A refused or full accumulate is the only source of a nonzero status.
  a_status_acc: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (cmd_reg == hkst_pkg::CMD_ACC))
    else $error("nonzero status on a command other than accumulate");

  // A successful accumulate reports an occupied slot holding its own key.
  a_acc_key: assert property (@(posedge clk) disable iff (rst)
    (done && !status && (cmd_reg == hkst_pkg::CMD_ACC) && !$past(state == ST_IDLE))
      |-> (occupied && (entry_key == key_reg)))
    else $error("accumulate result does not hold the accumulated key");

  // A clear gives its fixed empty result in the next cycle.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    ($past(accept && (command == hkst_pkg::CMD_CLEAR)) && !$past(rst))
      |-> (done && !occupied && !status))
    else $error("clear did not give its fixed result");

endmodule
